// ----- rtl/prm_pkg.sv -----
package prm_pkg;

   localparam int unsigned TicksDefault = 10;

   localparam logic [15:0] CutoffReset  = 16'd50;
   localparam logic [15:0] TimeoutReset = 16'd1000;
   localparam logic        CountReset   = 1'b0;
   localparam logic [15:0] WeightReset  = 16'd6554;

   localparam logic [63:0] UsPerMinute = 64'd60000000;
   localparam logic [31:0] MsPerMinute = 32'd60000;
   localparam logic [15:0] RateMax     = 16'hFFFF;

   localparam int unsigned DivW = 32;

   typedef enum logic [1:0] {
      OP_PULSE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_CUTOFF  = 2'd0,
      CSR_TIMEOUT = 2'd1,
      CSR_COUNT   = 2'd2,
      CSR_WEIGHT  = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PULSE,
      ST_EXEC,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } ring_ctl_type;

   typedef struct packed {
      logic            start;
      logic [DivW-1:0] dividend;
      logic [DivW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [DivW-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- rtl/prm_ring.sv -----
module prm_ring #(
   parameter int unsigned TICKS = prm_pkg::TicksDefault,
   parameter int unsigned PosW  = (TICKS > 1) ? $clog2(TICKS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  prm_pkg::ring_ctl_type ctl,
   input  logic [PosW-1:0]       addr,
   input  logic [31:0]           wr_data,
   output logic [31:0]           rd_data,
   output logic                  rd_valid
);
   import prm_pkg::*;

   logic [31:0]      times_mem [TICKS];
   logic [TICKS-1:0] valid_ff;
   logic [TICKS-1:0] valid_in;
   logic [31:0]      rd_data_ff;
   logic             rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         times_mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= times_mem[addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// ----- rtl/prm_div.sv -----
module prm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  prm_pkg::div_req_type req,
   output prm_pkg::div_rsp_type rsp
);
   import prm_pkg::*;

   localparam int unsigned CntW = $clog2(DivW);

   logic [DivW-1:0] rem_ff, rem_in;
   logic [DivW-1:0] quo_ff, quo_in;
   logic [DivW-1:0] den_ff, den_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DivW:0]   shifted;
   logic [DivW:0]   trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[DivW-1]};
      trial   = shifted - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DivW]) begin
            rem_in = trial[DivW-1:0];
            quo_in = {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DivW-1:0];
            quo_in = {quo_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(DivW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ----- rtl/pulse_rate_meter.sv -----
// Pulse rate meter: smoothed pulses per minute from timestamped events.
// Input channel req_*: one transaction carries req_op (pulse, read, clear)
// with req_time_us and req_time_ms. Result channel rsp_*: exactly one
// transaction per input, carrying rsp_rate_per_minute (integer part of the
// Q16.8 average) and rsp_total_pulses, in input order.
// Configuration channel csr_*: csr_index selects cutoff rate, stop timeout,
// count enable or smoothing weight; csr_ready is always high. Write only
// while no transaction is in flight.
// Path per op: a clear, an idle op, a read that clears or sees no elapsed
// time, or a pulse while the ring fills goes straight to the result. A pulse
// on a full ring or a decaying read passes through the 32-bit serial divider
// and then the blend (products registered, then summed); a read that divides
// but keeps the average skips the blend. One input is processed at a time,
// so no new input is taken until the last one has reached the result slot;
// req_ready is high only while idle.
// The result register holds a finished transaction while rsp_ready is low;
// the next input is still accepted and processed, then waits for the slot.
// Reset (synchronous) clears the average, counter, ring valid bits and ring
// position and restores register defaults; no clearing pass is needed.
module pulse_rate_meter #(
   parameter int unsigned TICKS = prm_pkg::TicksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_time_us,
   input  logic [31:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_rate_per_minute,
   output logic [31:0] rsp_total_pulses,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import prm_pkg::*;

   localparam int unsigned PosW     = (TICKS > 1) ? $clog2(TICKS) : 1;
   localparam logic [31:0] PulseNum = 32'(64'(TICKS) * UsPerMinute);
   localparam logic [PosW-1:0] PosLast = PosW'(TICKS - 1);

   state_type       state_ff, state_in;
   op_type          op_ff, op_in;
   logic [31:0]     time_us_ff, time_us_in;
   logic [31:0]     time_ms_ff, time_ms_in;
   logic [23:0]     smooth_ff, smooth_in;
   logic [31:0]     last_ms_ff, last_ms_in;
   logic [31:0]     count_ff, count_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [15:0]     val_ff, val_in;
   logic [39:0]     prod_a_ff, prod_a_in;
   logic [40:0]     prod_b_ff, prod_b_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     rsp_rate_ff, rsp_rate_in;
   logic [31:0]     rsp_total_ff, rsp_total_in;
   logic [15:0]     cutoff_ff, timeout_ff, weight_ff;
   logic            count_en_ff;

   ring_ctl_type    ring_ctl;
   logic [31:0]     ring_rdata;
   logic            ring_rvalid;
   div_req_type     div_req;
   div_rsp_type     div_rsp;

   logic [31:0]     span;
   logic [31:0]     elapsed;
   logic [15:0]     quo_sat;
   logic [16:0]     inv_weight;
   logic [41:0]     blend_sum;
   logic [PosW-1:0] pos_next;

   prm_ring #(
      .TICKS (TICKS),
      .PosW  (PosW)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ring_ctl),
      .addr     (pos_ff),
      .wr_data  (time_us_ff),
      .rd_data  (ring_rdata),
      .rd_valid (ring_rvalid)
   );

   prm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      span       = time_us_ff - ring_rdata;
      elapsed    = time_ms_ff - last_ms_ff;
      quo_sat    = (div_rsp.quotient[31:16] != 16'd0) ? RateMax : div_rsp.quotient[15:0];
      inv_weight = 17'h10000 - {1'b0, weight_ff};
      blend_sum  = {2'b00, prod_a_ff} + {1'b0, prod_b_ff} + 42'd32768;
      pos_next   = (pos_ff == PosLast) ? '0 : pos_ff + 1'b1;

      state_in     = state_ff;
      op_in        = op_ff;
      time_us_in   = time_us_ff;
      time_ms_in   = time_ms_ff;
      smooth_in    = smooth_ff;
      last_ms_in   = last_ms_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_total_in = rsp_total_ff;
      req_ready    = 1'b0;
      ring_ctl     = '0;
      div_req      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = op_type'(req_op);
               time_us_in = req_time_us;
               time_ms_in = req_time_ms;
               if (op_type'(req_op) == OP_PULSE) begin
                  ring_ctl.rd_en = 1'b1;
                  state_in       = ST_FETCH;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_PULSE;
         end
         ST_PULSE: begin
            if (count_en_ff) begin
               count_in = count_ff + 32'd1;
            end
            ring_ctl.wr_en = 1'b1;
            pos_in         = pos_next;
            if (ring_rvalid) begin
               div_req.start    = 1'b1;
               div_req.dividend = PulseNum;
               div_req.divisor  = span;
               last_ms_in       = time_ms_ff;
               state_in         = ST_DIV;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_EXEC: begin
            state_in = ST_OUT;
            unique case (op_ff)
               OP_READ: begin
                  if (smooth_ff < {cutoff_ff, 8'h00}) begin
                     smooth_in = '0;
                  end else if (elapsed > {16'd0, timeout_ff}) begin
                     smooth_in = '0;
                  end else if (elapsed != 32'd0) begin
                     div_req.start    = 1'b1;
                     div_req.dividend = MsPerMinute;
                     div_req.divisor  = elapsed;
                     state_in         = ST_DIV;
                  end
               end
               OP_CLEAR: begin
                  ring_ctl.clear = 1'b1;
                  pos_in         = '0;
                  smooth_in      = '0;
                  count_in       = '0;
                  last_ms_in     = time_ms_ff;
               end
               default: begin
               end
            endcase
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               val_in = quo_sat;
               if (op_ff == OP_PULSE) begin
                  state_in = ST_MUL;
               end else if (smooth_ff > {quo_sat, 8'h00}) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_MUL: begin
            prod_a_in = 40'({val_ff, 8'h00}) * 40'(weight_ff);
            prod_b_in = 41'(smooth_ff) * 41'(inv_weight);
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            smooth_in = blend_sum[39:16];
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = smooth_ff[23:8];
               rsp_total_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         smooth_ff    <= '0;
         last_ms_ff   <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         smooth_ff    <= smooth_in;
         last_ms_ff   <= last_ms_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      time_us_ff   <= time_us_in;
      time_ms_ff   <= time_ms_in;
      val_ff       <= val_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_total_ff <= rsp_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff   <= CutoffReset;
         timeout_ff  <= TimeoutReset;
         count_en_ff <= CountReset;
         weight_ff   <= WeightReset;
      end else if (csr_valid) begin
         unique case (csr_type'(csr_index))
            CSR_CUTOFF:  cutoff_ff   <= csr_data;
            CSR_TIMEOUT: timeout_ff  <= csr_data;
            CSR_COUNT:   count_en_ff <= csr_data[0];
            CSR_WEIGHT:  weight_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rate_per_minute = rsp_rate_ff;
   assign rsp_total_pulses    = rsp_total_ff;

endmodule
